// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// whole property, sampled on the rising clock edge
`define MDU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// same-cycle implication
`define MDU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define MDU_ASSERT(label, clk, rst, prop)
`define MDU_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

// File: src/mdu_pkg.sv
// ----------------------------------------------------------------------------
// mdu_pkg
// types and constants shared by the multiply/divide unit
// ----------------------------------------------------------------------------
package mdu_pkg;

   localparam int MDU_XLEN       = 32;   // port width of the data fields
   localparam int MDU_DATA_WIDTH = 32;   // default arithmetic width

   typedef enum logic [2:0] {
      OP_MULT  = 3'd0,
      OP_UMULT = 3'd1,
      OP_DIV   = 3'd2,
      OP_DIVU  = 3'd3,
      OP_MFHI  = 3'd4,
      OP_MFLO  = 3'd5,
      OP_MTHI  = 3'd6,
      OP_MTLO  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_ITER,
      ST_FIX
   } mdu_state_type;

   typedef struct packed {
      logic load;       // long operation accepted this cycle
      logic prep;       // operand magnitude cycle
      logic step;       // one bit of multiply or divide
      logic last;       // final bit step
      logic fix;        // result sign fixup, result captured
      logic is_div;
      logic is_signed;
   } mdu_ctl_type;

endpackage

// File: src/multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// multiply_divide_unit
// multiply/divide unit with hi and lo result registers, bit serial
// ----------------------------------------------------------------------------
// usage
//   an item (req_op, req_operand_a, req_operand_b) is taken at a rising edge
//   with start high and busy low. each item gives one result on rsp_* for a
//   single cycle, marked by rsp_strobe; the receiver must take it then.
// sequencing
//   mult, multu, div, divu: an operand magnitude state, DATA_WIDTH bit
//   steps of the shared shift-add / shift-subtract unit and a sign fixup
//   state, with busy high through all of them; the strobe is registered
//   from the fixup state. the next item can be taken in the strobe cycle.
//   mfhi, mflo, mthi, mtlo: strobe in the cycle after acceptance, busy stays
//   low, one item per cycle.
// reset
//   synchronous, clears hi, lo, the sequencer and the strobe.
// signed division truncates toward zero; divide by zero and the most
// negative value over minus one fall out of the same restoring datapath
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multiply_divide_unit import mdu_pkg::*; #(
   parameter int DATA_WIDTH = MDU_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_op,
   input  logic [MDU_XLEN-1:0] req_operand_a,
   input  logic [MDU_XLEN-1:0] req_operand_b,
   output logic                rsp_strobe,
   output logic [MDU_XLEN-1:0] rsp_read_value,
   output logic [MDU_XLEN-1:0] rsp_hi_after,
   output logic [MDU_XLEN-1:0] rsp_lo_after
);

   localparam int W = DATA_WIDTH;

   mdu_ctl_type   ctl;
   logic          accept;
   logic [W-1:0]  op_a, op_b;
   logic [W-1:0]  res_hi, res_lo;

   // architectural hi/lo
   logic [W-1:0]  hi_ff, hi_in;
   logic [W-1:0]  lo_ff, lo_in;
   // result output register
   logic          strobe_ff, strobe_in;
   logic [W-1:0]  rd_ff, rd_in;

   // operands reduced to the arithmetic width
   assign op_a   = req_operand_a[W-1:0];
   assign op_b   = req_operand_b[W-1:0];
   assign accept = start && !busy;

   mdu_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_op),
      .busy  (busy),
      .ctl   (ctl)
   );

   mdu_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock  (clock),
      .ctl    (ctl),
      .op_a   (op_a),
      .op_b   (op_b),
      .res_hi (res_hi),
      .res_lo (res_lo)
   );

   // a move or read can't coincide with the fixup cycle, busy is high there
   always_comb begin
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      rd_in     = '0;
      strobe_in = 1'b0;
      priority if (ctl.fix) begin
         hi_in     = res_hi;
         lo_in     = res_lo;
         strobe_in = 1'b1;
      end else if (accept && req_op[2]) begin
         strobe_in = 1'b1;
         unique case (op_type'(req_op))
            OP_MFHI: begin
               rd_in = hi_ff;
            end
            OP_MFLO: begin
               rd_in = lo_ff;
            end
            OP_MTHI: begin
               hi_in = op_a;
            end
            OP_MTLO: begin
               lo_in = op_a;
            end
            OP_MULT, OP_UMULT, OP_DIV, OP_DIVU: begin
               // handled by the sequencer
               strobe_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff     <= '0;
         lo_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         hi_ff     <= hi_in;
         lo_ff     <= lo_in;
         strobe_ff <= strobe_in;
      end
      rd_ff <= rd_in;
   end

   // hi/lo are the result's after-values once the strobe is up
   assign rsp_strobe     = strobe_ff;
   assign rsp_read_value = MDU_XLEN'(rd_ff);
   assign rsp_hi_after   = MDU_XLEN'(hi_ff);
   assign rsp_lo_after   = MDU_XLEN'(lo_ff);

   `MDU_ASSERT_IMP(a_done_strobe, clock, reset, $fell(busy) && !$past(reset), rsp_strobe)
   `MDU_ASSERT(a_mthi_load, clock, reset, (accept && req_op == OP_MTHI) |=> (hi_ff == $past(op_a)))
   `MDU_ASSERT(a_mfhi_read, clock, reset, (accept && req_op == OP_MFHI) |=> (rsp_strobe && rsp_read_value == rsp_hi_after))

endmodule

// File: src/mdu_ctrl.sv
// ----------------------------------------------------------------------------
// mdu_ctrl
// sequencer for the bit-serial multiply and divide
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdu_ctrl import mdu_pkg::*; #(
   parameter int DATA_WIDTH = MDU_DATA_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  op,
   output logic        busy,
   output mdu_ctl_type ctl
);

   localparam int CW = $clog2(DATA_WIDTH);

   mdu_state_type   state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            div_ff, div_in;
   logic            sgn_ff, sgn_in;
   logic            accept;
   logic            op_long;
   logic            op_div;
   logic            op_signed;
   logic            last_step;

   always_comb begin
      op_long   = 1'b0;
      op_div    = 1'b0;
      op_signed = 1'b0;
      unique case (op_type'(op))
         OP_MULT: begin
            op_long   = 1'b1;
            op_signed = 1'b1;
         end
         OP_UMULT: begin
            op_long = 1'b1;
         end
         OP_DIV: begin
            op_long   = 1'b1;
            op_div    = 1'b1;
            op_signed = 1'b1;
         end
         OP_DIVU: begin
            op_long = 1'b1;
            op_div  = 1'b1;
         end
         OP_MFHI, OP_MFLO, OP_MTHI, OP_MTLO: begin
            op_long = 1'b0;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign last_step = (state_ff == ST_ITER) && (cnt_ff == CW'(DATA_WIDTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && op_long) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_ITER;
            cnt_in   = '0;
         end
         ST_ITER: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign div_in = (accept && op_long) ? op_div    : div_ff;
   assign sgn_in = (accept && op_long) ? op_signed : sgn_ff;

   // outputs
   always_comb begin
      ctl.load      = accept && op_long;
      ctl.prep      = (state_ff == ST_PREP);
      ctl.step      = (state_ff == ST_ITER);
      ctl.last      = last_step;
      ctl.fix       = (state_ff == ST_FIX);
      ctl.is_div    = ctl.load ? op_div    : div_ff;
      ctl.is_signed = ctl.load ? op_signed : sgn_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      sgn_ff <= sgn_in;
   end

   `MDU_ASSERT(a_long_prep, clock, reset, (accept && op_long) |=> (state_ff == ST_PREP))
   `MDU_ASSERT(a_last_fix, clock, reset, last_step |=> (state_ff == ST_FIX))
   `MDU_ASSERT(a_fix_once, clock, reset, (state_ff == ST_FIX) |=> (state_ff == ST_IDLE))

endmodule

// File: src/mdu_datapath.sv
// ----------------------------------------------------------------------------
// mdu_datapath
// shift registers and the shared add/subtract for multiply and divide
// ----------------------------------------------------------------------------
module mdu_datapath import mdu_pkg::*; #(
   parameter int DATA_WIDTH = MDU_DATA_WIDTH
) (
   input  logic                  clock,
   input  mdu_ctl_type           ctl,
   input  logic [DATA_WIDTH-1:0] op_a,
   input  logic [DATA_WIDTH-1:0] op_b,
   output logic [DATA_WIDTH-1:0] res_hi,
   output logic [DATA_WIDTH-1:0] res_lo
);

   localparam int W = DATA_WIDTH;

   logic [W:0]   acc_ff, acc_in;     // partial product high part / remainder
   logic [W-1:0] mq_ff, mq_in;       // multiplier bits out / quotient bits in
   logic [W:0]   opnd_ff, opnd_in;   // multiplicand or divisor
   logic         nneg_ff, nneg_in;   // dividend negative
   logic         qneg_ff, qneg_in;   // quotient negative
   logic [W+1:0] add_x, add_y, add_sum;
   logic         add_sub;

   // one adder serves both operations
   always_comb begin
      if (ctl.is_div) begin
         add_x   = {1'b0, acc_ff[W-1:0], mq_ff[W-1]};
         add_y   = {1'b0, opnd_ff};
         add_sub = 1'b1;
      end else begin
         add_x   = {acc_ff[W], acc_ff};
         add_y   = mq_ff[0] ? {opnd_ff[W], opnd_ff} : '0;
         // sign bit of a signed multiplier has negative weight
         add_sub = ctl.is_signed && ctl.last;
      end
      add_sum = add_sub ? (add_x - add_y) : (add_x + add_y);
   end

   always_comb begin
      acc_in  = acc_ff;
      mq_in   = mq_ff;
      opnd_in = opnd_ff;
      nneg_in = nneg_ff;
      qneg_in = qneg_ff;
      priority if (ctl.load) begin
         acc_in  = '0;
         nneg_in = ctl.is_signed && op_a[W-1];
         qneg_in = ctl.is_signed && (op_a[W-1] ^ op_b[W-1]);
         if (ctl.is_div) begin
            mq_in   = op_a;
            opnd_in = {1'b0, op_b};
         end else begin
            mq_in   = op_b;
            opnd_in = {ctl.is_signed && op_a[W-1], op_a};
         end
      end else if (ctl.prep) begin
         // magnitudes for signed divide
         if (ctl.is_div) begin
            mq_in = nneg_ff ? ('0 - mq_ff) : mq_ff;
            opnd_in = {1'b0, (nneg_ff ^ qneg_ff) ? ('0 - opnd_ff[W-1:0])
                                                 : opnd_ff[W-1:0]};
         end
      end else if (ctl.step) begin
         if (ctl.is_div) begin
            if (add_sum[W+1]) begin
               acc_in = {1'b0, add_x[W-1:0]};
               mq_in  = {mq_ff[W-2:0], 1'b0};
            end else begin
               acc_in = {1'b0, add_sum[W-1:0]};
               mq_in  = {mq_ff[W-2:0], 1'b1};
            end
         end else begin
            acc_in = add_sum[W+1:1];
            mq_in  = {add_sum[0], mq_ff[W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mq_ff   <= mq_in;
      opnd_ff <= opnd_in;
      nneg_ff <= nneg_in;
      qneg_ff <= qneg_in;
   end

   // sign fixup, valid while ctl.fix is high
   assign res_hi = (ctl.is_div && nneg_ff) ? ('0 - acc_ff[W-1:0]) : acc_ff[W-1:0];
   assign res_lo = (ctl.is_div && qneg_ff) ? ('0 - mq_ff) : mq_ff;

endmodule

// File: verif/multiply_divide_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiply_divide_unit_test
// self-checking bench for the hi/lo multiply/divide unit: a queue-fed driver
// issues directed corner items then random op sequences with random idle gaps,
// a hi/lo predictor computes each expected result and a monitor compares every
// strobed result field by field
// ----------------------------------------------------------------------------
module multiply_divide_unit_test;
   import mdu_pkg::*;

   // one item as queued for the driver
   typedef struct {
      op_type      op;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
      int unsigned idle_before;   // low cycles on start before this item
      bit          wait_drain;    // hold off until all results are back
   } mdu_request_type;

   // one result as seen on the rsp_ ports
   typedef struct packed {
      logic [31:0] read_value;
      logic [31:0] hi_after;
      logic [31:0] lo_after;
   } hilo_result_type;

   localparam int unsigned RANDOM_ITEMS = 1450;
   localparam int unsigned DRAIN_EVERY  = 250;
   localparam int unsigned TAIL_CYCLES  = 50;   // longer than a full divide

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_op = OP_MFHI;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_read_value;
   logic [31:0] rsp_hi_after;
   logic [31:0] rsp_lo_after;

   // stimulus and scoreboard
   mdu_request_type pending_requests[$];
   hilo_result_type expected_hilo[$];
   mdu_request_type cur_request;
   bit           request_loaded = 1'b0;
   int unsigned  idle_left = 0;
   int unsigned  items_accepted = 0;   // written by the driver only
   int unsigned  results_seen = 0;     // written by the monitor only
   int unsigned  error_count = 0;
   int unsigned  op_seen[8];
   int unsigned  zero_divides = 0;
   int unsigned  overflow_divides = 0;
   bit           burst_mode = 1'b0;

   // predictor copy of the architectural registers
   logic [31:0]  hi_model = '0;
   logic [31:0]  lo_model = '0;

   multiply_divide_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_hi_after   (rsp_hi_after),
      .rsp_lo_after   (rsp_lo_after)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // hi/lo predictor: applies one item to the model registers and returns
   // the result it must produce
   // ---------------------------------------------------------------------
   function automatic hilo_result_type predict_hilo(input op_type op,
                                                    input logic [31:0] a,
                                                    input logic [31:0] b);
      hilo_result_type res;
      logic [63:0]  product;
      logic [31:0]  a_mag;
      logic [31:0]  b_mag;
      logic [31:0]  quot;
      logic [31:0]  rem;
      res = '0;
      // magnitudes; the most negative value keeps its own bit pattern,
      // which read unsigned is its true magnitude
      a_mag = a[31] ? -a : a;
      b_mag = b[31] ? -b : b;
      case (op)
         OP_MULT: begin
            product = longint'($signed(a)) * longint'($signed(b));
            {hi_model, lo_model} = product;
         end
         OP_UMULT: begin
            product = {32'd0, a} * {32'd0, b};
            {hi_model, lo_model} = product;
         end
         OP_DIV: begin
            if (b == '0) begin
               // zero divisor: dividend to hi, lo is 1 for a negative
               // dividend and all ones otherwise
               hi_model = a;
               lo_model = a[31] ? 32'd1 : '1;
            end else begin
               // truncating toward zero: the remainder follows the dividend;
               // most negative over minus one wraps to itself with rem 0
               quot     = a_mag / b_mag;
               rem      = a_mag % b_mag;
               lo_model = (a[31] ^ b[31]) ? -quot : quot;
               hi_model = a[31] ? -rem : rem;
            end
         end
         OP_DIVU: begin
            if (b == '0) begin
               hi_model = a;
               lo_model = '1;
            end else begin
               hi_model = a % b;
               lo_model = a / b;
            end
         end
         OP_MFHI: res.read_value = hi_model;
         OP_MFLO: res.read_value = lo_model;
         OP_MTHI: hi_model = a;
         OP_MTLO: lo_model = a;
      endcase
      res.hi_after = hi_model;
      res.lo_after = lo_model;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // driver: an item is taken at an edge with start high and busy low; the
   // next one, for a drain item only once all results are back, goes out at once or after its idle gap
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit was_taken;
      bit present;
      if (reset) begin
         start          <= 1'b0;
         req_op         <= OP_MFHI;
         req_operand_a  <= '0;
         req_operand_b  <= '0;
         items_accepted <= 0;
         request_loaded = 1'b0;
         hi_model       = '0;
         lo_model       = '0;
      end else if (!(start && busy)) begin
         // not held off: either the item went in now or start was low
         was_taken = start;
         present   = 1'b0;
         if (was_taken) begin
            expected_hilo.push_back(predict_hilo(cur_request.op, cur_request.operand_a,
                                                 cur_request.operand_b));
            items_accepted <= items_accepted + 1;
            op_seen[cur_request.op]++;
            if (cur_request.op inside {OP_DIV, OP_DIVU} && cur_request.operand_b == '0)
               zero_divides++;
            if (cur_request.op == OP_DIV && cur_request.operand_a == 32'h8000_0000 &&
                cur_request.operand_b == '1)
               overflow_divides++;
            request_loaded = 1'b0;
         end
         if (!request_loaded && pending_requests.size() > 0) begin
            cur_request    = pending_requests.pop_front();
            request_loaded = 1'b1;
            idle_left      = cur_request.idle_before;
         end
         if (request_loaded) begin
            if (idle_left > 0)
               idle_left--;
            else if (!cur_request.wait_drain)
               present = 1'b1;
            // drain: start was low at this edge, so both counts are settled
            else if (!was_taken && results_seen == items_accepted)
               present = 1'b1;
         end
         if (present) begin
            start         <= 1'b1;
            req_op        <= cur_request.op;
            req_operand_a <= cur_request.operand_a;
            req_operand_b <= cur_request.operand_b;
         end else begin
            // junk on the payload while start is low
            start         <= 1'b0;
            req_op        <= 3'($urandom);
            req_operand_a <= $urandom;
            req_operand_b <= $urandom;
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every strobed result is checked against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %h, got %h", name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      hilo_result_type want;
      if (reset) begin
         results_seen <= 0;
      end else if (rsp_strobe) begin
         // items_accepted is the count before this edge, so a result for
         // an item taken at this same edge can not be matched by mistake
         if (results_seen >= items_accepted) begin
            $error("result with no item outstanding: read %h hi %h lo %h",
                   rsp_read_value, rsp_hi_after, rsp_lo_after);
            error_count++;
         end else begin
            want = expected_hilo.pop_front();
            check_field("read_value", want.read_value, rsp_read_value);
            check_field("hi_after", want.hi_after, rsp_hi_after);
            check_field("lo_after", want.lo_after, rsp_lo_after);
            results_seen <= results_seen + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   // mostly back to back or short gaps, now and then a long one that lands
   // inside a running divide or after it
   function automatic int unsigned draw_gap();
      int unsigned pick;
      if (burst_mode)
         return 0;
      pick = $urandom_range(0, 19);
      if (pick < 10) return 0;
      if (pick < 17) return $urandom_range(1, 3);
      if (pick < 19) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // operand mix: corner values, small magnitudes of both signs, full range
   function automatic logic [31:0] draw_operand();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 4))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'hFFFF_FFFF;
               3: return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         1: return 32'($urandom_range(0, 15));
         2: return -32'($urandom_range(1, 15));
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_request(input op_type op, input logic [31:0] a,
                                input logic [31:0] b, input bit drain = 1'b0);
      mdu_request_type req;
      req.op          = op;
      req.operand_a   = a;
      req.operand_b   = b;
      req.idle_before = draw_gap();
      req.wait_drain  = drain;
      pending_requests.push_back(req);
   endtask

   // a long op or a move into hi/lo, with random operands and the odd
   // zero divisor or overflowing divide
   task automatic queue_producer(input bit drain);
      op_type      op;
      logic [31:0] a;
      logic [31:0] b;
      case ($urandom_range(0, 9))
         0, 1:    op = OP_MULT;
         2:       op = OP_UMULT;
         3, 4, 5: op = OP_DIV;
         6, 7:    op = OP_DIVU;
         8:       op = OP_MTHI;
         default: op = OP_MTLO;
      endcase
      a = draw_operand();
      b = draw_operand();
      if (op inside {OP_DIV, OP_DIVU} && $urandom_range(0, 11) == 0)
         b = '0;
      if (op == OP_DIV && $urandom_range(0, 39) == 0) begin
         a = 32'h8000_0000;
         b = '1;
      end
      queue_request(op, a, b, drain);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned queued;
      int unsigned reads;
      int unsigned next_drain;

      // directed corners; moves carry a random operand_b that must be ignored
      queue_request(OP_MTHI, 32'hFFFF_FFFF, $urandom);
      queue_request(OP_MTLO, 32'h8000_0000, $urandom);
      queue_request(OP_MFHI, $urandom, $urandom);
      queue_request(OP_MFLO, $urandom, $urandom);
      queue_request(OP_MULT, 32'h8000_0000, 32'h8000_0000);
      queue_request(OP_MULT, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_request(OP_MULT, 32'hFFFF_FFFF, 32'h0000_0001);
      queue_request(OP_UMULT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(OP_UMULT, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_request(OP_MFHI, '0, '0);
      // most negative over minus one
      queue_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_request(OP_DIV, 32'h8000_0000, 32'h0000_0001);
      // truncation toward zero with a negative dividend, divisor or both
      queue_request(OP_DIV, -32'd7, 32'd2);
      queue_request(OP_DIV, 32'd7, -32'd2);
      queue_request(OP_DIV, -32'd7, -32'd2);
      // divide by zero, signed with both dividend signs, and unsigned
      queue_request(OP_DIV, 32'd5, 32'd0);
      queue_request(OP_MFLO, '0, '0);
      queue_request(OP_DIV, -32'd5, 32'd0);
      queue_request(OP_DIV, 32'd0, 32'd0);
      queue_request(OP_DIVU, 32'hFFFF_FFFB, 32'd0);
      queue_request(OP_DIVU, 32'hFFFF_FFFF, 32'd1);
      queue_request(OP_DIVU, 32'd0, 32'hFFFF_FFFF);
      queue_request(OP_MFHI, '1, '1);
      queue_request(OP_MFLO, '1, '1);

      // random part: mostly a producer followed by up to two reads of hi or lo, the
      // rest single ops of any kind; stretches of back-to-back items
      // alternate with gappy ones, and every so often the sender drains
      queued     = 0;
      next_drain = 0;
      while (queued < RANDOM_ITEMS) begin
         if (queued % 60 < 2)
            burst_mode = $urandom_range(0, 2) == 0;
         if ($urandom_range(0, 9) < 7) begin
            queue_producer(queued >= next_drain);
            queued++;
            reads = $urandom_range(0, 2);
            repeat (reads) begin
               queue_request(op_type'($urandom_range(0, 1) ? OP_MFHI : OP_MFLO),
                             $urandom, $urandom);
               queued++;
            end
         end else begin
            queue_request(op_type'($urandom_range(0, 7)), draw_operand(), draw_operand(),
                          queued >= next_drain);
            queued++;
         end
         if (queued >= next_drain)
            next_drain = queued + DRAIN_EVERY;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every item taken, then every result back, then a quiet tail so a
      // stray strobe still gets caught
      while (pending_requests.size() != 0 || request_loaded || start)
         @(negedge clock);
      while (results_seen != items_accepted)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("tb: %0d items checked: mult %0d multu %0d div %0d divu %0d",
               results_seen, op_seen[OP_MULT], op_seen[OP_UMULT], op_seen[OP_DIV],
               op_seen[OP_DIVU]);
      $display("tb: mfhi %0d mflo %0d mthi %0d mtlo %0d, zero divisors %0d, overflow %0d",
               op_seen[OP_MFHI], op_seen[OP_MFLO], op_seen[OP_MTHI], op_seen[OP_MTLO],
               zero_divides, overflow_divides);
      if (error_count == 0 && expected_hilo.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
